>>> hdl/bfcc_pkg.sv
// Shared types, constants and the CRC byte update for the bus frame CRC checker.
package bfcc_pkg;

	localparam logic [15:0] CRC_INIT      = 16'hFFFF;
	localparam logic [15:0] POLY_RESET    = 16'h1021;
	localparam logic [8:0]  POS_MAX       = 9'd511;
	localparam int          QUEUE_DEPTH   = 4;
	localparam int          QPTR_W        = $clog2(QUEUE_DEPTH);
	localparam int          QCNT_W        = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		STATUS_OK     = 2'd0,
		STATUS_LENGTH = 2'd1,
		STATUS_CRC    = 2'd2
	} frame_status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_frame;
	} in_item_t;

	typedef struct packed {
		logic [7:0]    out_byte;
		logic [7:0]    out_index;
		logic [7:0]    dest_address;
		logic          frame_done;
		frame_status_t frame_status;
	} out_item_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
		input logic [7:0] b_in, input logic [15:0] poly);
		logic [15:0] c;
		logic [7:0]  b;
		logic        fb;
		c = crc_in;
		b = b_in;
		for (int i = 0; i < 8; i++) begin
			fb = c[15] ^ b[7];
			c = {c[14:0], 1'b0};
			if (fb) begin
				c = c ^ poly;
			end
			b = {b[6:0], 1'b0};
		end
		return c;
	endfunction

endpackage

>>> hdl/bus_frame_crc_checker.sv
// Top level of the bus frame CRC checker: front end, result queue, output stage.
//
//  channel   | handshake          | payload
//  ----------+--------------------+-------------------------------------------
//  input     | push / full        | in_item  (data_byte, end_of_frame)
//  result    | pop / empty        | result   (out_byte, out_index, dest_address,
//            |                    |           frame_done, frame_status)
//  config    | cfg_valid/cfg_ready| cfg_data (CRC polynomial)
//
// One byte is taken every cycle while full is low; its CRC is computed in the
// cycle it is taken. Result words pass the queue, then the output register.
// full rises once four words wait in the queue behind a held output word.
// Reset clears all frame state and loads polynomial 0x1021; no clearing pass.
// cfg_ready is always high.
module bus_frame_crc_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  bfcc_pkg::in_item_t   in_item,
	input  logic                 pop,
	output logic                 empty,
	output bfcc_pkg::out_item_t  result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [15:0]          cfg_data
);

	logic                accept;
	logic                front_valid;
	bfcc_pkg::out_item_t front_word;
	logic                q_empty;
	logic                q_pop;
	bfcc_pkg::out_item_t q_data;

	assign cfg_ready = 1'b1;
	assign accept    = push && !full;

	bfcc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.in_item   (in_item),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.res_valid (front_valid),
		.res_word  (front_word)
	);

	bfcc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept && front_valid),
		.wr_data (front_word),
		.full    (full),
		.rd_en   (q_pop),
		.empty   (q_empty),
		.rd_data (q_data)
	);

	bfcc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (q_data),
		.q_pop   (q_pop),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

	a_eof_enqueues: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_item.end_of_frame) |-> front_valid)
		else $error("end of frame produced no status word");

	a_queue_drains: assert property (@(posedge clk) disable iff (!arst_n)
		!q_empty |=> !empty)
		else $error("queued word not moved to output");

	a_payload_status: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.frame_done) |-> (result.frame_status == bfcc_pkg::STATUS_OK))
		else $error("payload word carries a status");

endmodule

>>> hdl/bfcc_front.sv
// Front end: frame parsing, CRC update and result word generation.
module bfcc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  bfcc_pkg::in_item_t   in_item,
	input  logic                 cfg_valid,
	input  logic [15:0]          cfg_data,
	output logic                 res_valid,
	output bfcc_pkg::out_item_t  res_word
);

	logic [15:0] poly_q;
	logic [8:0]  pos_q, pos_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  len_q, len_d;
	logic [7:0]  dest_q, dest_d;
	logic [7:0]  crc_hi_q, crc_hi_d;
	logic        overrun_q, overrun_d;

	logic [7:0]  b;
	logic [7:0]  dest_now;
	logic [7:0]  len_now;
	logic [8:0]  crc_start;
	logic        in_span;
	logic        is_payload;
	logic        len_err;

	assign b = in_item.data_byte;

	always_comb begin
		dest_now   = (pos_q == 9'd0) ? b : dest_q;
		len_now    = (pos_q == 9'd1) ? b : len_q;
		crc_start  = {1'b0, len_now} + 9'd2;
		in_span    = (pos_q < 9'd2) || (pos_q < crc_start);
		is_payload = (pos_q >= 9'd2) && (pos_q < crc_start);
		len_err    = overrun_q || (pos_q != ({1'b0, len_now} + 9'd3));

		pos_d     = pos_q;
		crc_d     = crc_q;
		len_d     = len_now;
		dest_d    = dest_now;
		crc_hi_d  = crc_hi_q;
		overrun_d = overrun_q;

		res_valid             = 1'b0;
		res_word.out_byte     = 8'd0;
		res_word.out_index    = 8'd0;
		res_word.dest_address = dest_now;
		res_word.frame_done   = 1'b0;
		res_word.frame_status = bfcc_pkg::STATUS_OK;

		if (in_item.end_of_frame) begin
			res_valid           = 1'b1;
			res_word.frame_done = 1'b1;
			priority if (len_err) begin
				res_word.frame_status = bfcc_pkg::STATUS_LENGTH;
			end else if ({crc_hi_q, b} == crc_q) begin
				res_word.frame_status = bfcc_pkg::STATUS_OK;
			end else begin
				res_word.frame_status = bfcc_pkg::STATUS_CRC;
			end
			pos_d     = 9'd0;
			crc_d     = bfcc_pkg::CRC_INIT;
			len_d     = 8'd0;
			dest_d    = 8'd0;
			crc_hi_d  = 8'd0;
			overrun_d = 1'b0;
		end else begin
			priority if (in_span) begin
				crc_d = bfcc_pkg::crc_byte(crc_q, b, poly_q);
			end else if (pos_q == crc_start) begin
				crc_hi_d = b;
			end else if (pos_q > (crc_start + 9'd1)) begin
				overrun_d = 1'b1;
			end else begin
				crc_hi_d = crc_hi_q;
			end
			if (pos_q < bfcc_pkg::POS_MAX) begin
				pos_d = pos_q + 9'd1;
			end
			if (is_payload) begin
				res_valid          = 1'b1;
				res_word.out_byte  = b;
				res_word.out_index = 8'(pos_q - 9'd2);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q <= bfcc_pkg::POLY_RESET;
		end else if (cfg_valid) begin
			poly_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= 9'd0;
			crc_q     <= bfcc_pkg::CRC_INIT;
			len_q     <= 8'd0;
			dest_q    <= 8'd0;
			crc_hi_q  <= 8'd0;
			overrun_q <= 1'b0;
		end else if (accept) begin
			pos_q     <= pos_d;
			crc_q     <= crc_d;
			len_q     <= len_d;
			dest_q    <= dest_d;
			crc_hi_q  <= crc_hi_d;
			overrun_q <= overrun_d;
		end
	end

endmodule

>>> hdl/bfcc_queue.sv
// Small result word queue between the front end and the output stage.
module bfcc_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  bfcc_pkg::out_item_t  wr_data,
	output logic                 full,
	input  logic                 rd_en,
	output logic                 empty,
	output bfcc_pkg::out_item_t  rd_data
);

	bfcc_pkg::out_item_t               mem_q [bfcc_pkg::QUEUE_DEPTH];
	logic [bfcc_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [bfcc_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [bfcc_pkg::QCNT_W-1:0]       count_q;

	assign full    = (count_q == bfcc_pkg::QCNT_W'(bfcc_pkg::QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> hdl/bfcc_back.sv
// Output stage: holds the oldest result word on the result ports.
module bfcc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	input  bfcc_pkg::out_item_t  q_data,
	output logic                 q_pop,
	input  logic                 pop,
	output logic                 empty,
	output bfcc_pkg::out_item_t  result
);

	logic                valid_q;
	bfcc_pkg::out_item_t out_q;

	assign q_pop  = !q_empty && (!valid_q || pop);
	assign empty  = !valid_q;
	assign result = out_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_q <= q_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

endmodule
